@@ design/b64e_pkg.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the alphabet lookup for the base64 stream encoder.
// -----------------------------------------------------------------------------
package b64e_pkg;

    localparam int unsigned CmdDepth  = 2;
    localparam int unsigned CmdPtrW   = (CmdDepth > 1) ? $clog2(CmdDepth) : 1;
    localparam int unsigned CmdLevelW = $clog2(CmdDepth + 1);
    localparam int unsigned MaxChars  = 4;
    localparam int unsigned CharSelW  = $clog2(MaxChars);

    localparam logic [7:0] PadChar   = 8'h3D;
    localparam logic [7:0] StdCh62   = 8'h2B;
    localparam logic [7:0] StdCh63   = 8'h2F;
    localparam logic [7:0] UrlCh62   = 8'h2D;
    localparam logic [7:0] UrlCh63   = 8'h5F;
    localparam logic [7:0] UpperBase = 8'd65;
    localparam logic [7:0] LowerOffs = 8'd71;
    localparam logic [7:0] DigitOffs = 8'd4;

    typedef logic [5:0] sextet_t;

    // one byte's worth of characters: sextets or pads, last_sel = count - 1
    typedef struct packed {
        logic [MaxChars-1:0][5:0] sym;
        logic [MaxChars-1:0]      pad;
        logic [CharSelW-1:0]      last_sel;
        logic                     last;
    } cmd_t;

    function automatic logic [7:0] b64e_map(input sextet_t idx, input logic url);
        logic [7:0] x;
        x = {2'b00, idx};
        if (idx < 6'd26)
        begin
            return x + UpperBase;
        end
        else if (idx < 6'd52)
        begin
            return x + LowerOffs;
        end
        else if (idx < 6'd62)
        begin
            return x - DigitOffs;
        end
        else if (idx == 6'd62)
        begin
            return url ? UrlCh62 : StdCh62;
        end
        else
        begin
            return url ? UrlCh63 : StdCh63;
        end
    endfunction

endpackage
`default_nettype wire

@@ design/b64e_if.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// b64e_if
// Valid/ready stream interfaces: raw message bytes in, base64 characters out.
// -----------------------------------------------------------------------------
interface b64e_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64e_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_char;

    modport source (output valid, output out_char, output last_char, input ready);
    modport sink   (input valid, input out_char, input last_char, output ready);
endinterface
`default_nettype wire

@@ design/b64e_front.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// b64e_front
// Accepts message bytes, tracks group position and leftover bits, and builds
// the character command for each byte.
// -----------------------------------------------------------------------------
module b64e_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          url,
    b64e_byte_if.sink          byte_in,
    output b64e_pkg::cmd_t     cmd,
    output logic               cmd_push,
    input  wire logic          cmd_full
);
    import b64e_pkg::*;

    localparam logic [1:0] PosFirst  = 2'd0;
    localparam logic [1:0] PosSecond = 2'd1;
    localparam logic [1:0] PosThird  = 2'd2;

    logic [1:0] pos_reg, pos_next;
    logic [3:0] left_reg, left_next;
    logic [7:0] b;

    assign b             = byte_in.data_byte;
    assign byte_in.ready = !cmd_full;
    assign cmd_push      = byte_in.valid && !cmd_full;

    always_comb
    begin
        cmd          = '0;
        cmd.last     = byte_in.last_byte;
        cmd.pad[2]   = 1'b1;
        cmd.pad[3]   = 1'b1;
        pos_next     = pos_reg;
        left_next    = left_reg;
        case (pos_reg)
            PosSecond:
            begin
                cmd.sym[0]   = {left_reg[1:0], b[7:4]};
                cmd.sym[1]   = {b[3:0], 2'b00};
                cmd.last_sel = byte_in.last_byte ? (url ? 2'd1 : 2'd2) : 2'd0;
                left_next    = b[3:0];
                pos_next     = PosThird;
            end
            PosThird:
            begin
                cmd.sym[0]   = {left_reg, b[7:6]};
                cmd.sym[1]   = b[5:0];
                cmd.last_sel = 2'd1;
                left_next    = 4'd0;
                pos_next     = PosFirst;
            end
            default:
            begin
                cmd.sym[0]   = b[7:2];
                cmd.sym[1]   = {b[1:0], 4'b0000};
                cmd.last_sel = byte_in.last_byte ? (url ? 2'd1 : 2'd3) : 2'd0;
                left_next    = {2'b00, b[1:0]};
                pos_next     = PosSecond;
            end
        endcase
        if (byte_in.last_byte)
        begin
            left_next = 4'd0;
            pos_next  = PosFirst;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= PosFirst;
            left_reg <= 4'd0;
        end
        else if (cmd_push)
        begin
            pos_reg  <= pos_next;
            left_reg <= left_next;
        end
    end

endmodule
`default_nettype wire

@@ design/b64e_cmd_fifo.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// b64e_cmd_fifo
// Short command queue between the byte front end and the character back end.
// -----------------------------------------------------------------------------
module b64e_cmd_fifo (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  b64e_pkg::cmd_t                  push_cmd,
    input  wire logic                       pop,
    output b64e_pkg::cmd_t                  head,
    output logic                            empty,
    output logic                            full,
    output logic [b64e_pkg::CmdLevelW-1:0]  level
);
    import b64e_pkg::*;

    cmd_t                  mem_reg [CmdDepth];
    logic [CmdPtrW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [CmdPtrW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CmdLevelW-1:0]  level_reg, level_next;
    logic                  do_push, do_pop;

    assign empty   = (level_reg == '0);
    assign full    = (level_reg == CmdLevelW'(CmdDepth));
    assign level   = level_reg;
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == CmdPtrW'(CmdDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == CmdPtrW'(CmdDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule
`default_nettype wire

@@ design/b64e_back.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// b64e_back
// Walks each queued command one character per beat, maps sextets through the
// selected alphabet and holds the result in the output register.
// -----------------------------------------------------------------------------
module b64e_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          url,
    input  b64e_pkg::cmd_t     head,
    input  wire logic          head_valid,
    output logic               pop,
    b64e_char_if.source        char_out
);
    import b64e_pkg::*;

    logic [CharSelW-1:0] sel_reg, sel_next;
    logic                valid_reg;
    logic [7:0]          char_reg, char_next;
    logic                lastc_reg, lastc_next;
    logic                load;

    assign load = head_valid && (!valid_reg || char_out.ready);
    assign pop  = load && (sel_reg == head.last_sel);

    always_comb
    begin
        char_next  = head.pad[sel_reg] ? PadChar : b64e_map(head.sym[sel_reg], url);
        lastc_next = head.last && (sel_reg == head.last_sel);
        sel_next   = sel_reg;
        if (pop)
        begin
            sel_next = '0;
        end
        else if (load)
        begin
            sel_next = sel_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            sel_reg <= sel_next;
            if (load)
            begin
                valid_reg <= 1'b1;
            end
            else if (char_out.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg  <= char_next;
            lastc_reg <= lastc_next;
        end
    end

    assign char_out.valid     = valid_reg;
    assign char_out.out_char  = char_reg;
    assign char_out.last_char = lastc_reg;

endmodule
`default_nettype wire

@@ design/base64_stream_encoder.sv @@
`default_nettype none
// Each byte's command goes through the queue, then the output register drives char_out.
// The output register gives one character beat per cycle while char_out is ready; a byte
// yields one to four characters, and three bytes mid-message yield four characters.
// A two-entry command queue lets byte_in keep taking beats while char_out stalls, until it fills.
// Reset (rst_n, async low): variant standard, group position and leftover bits cleared,
// queue and output register empty.
// -----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming base64 encoder: bytes in, standard or URL-safe characters out.
// -----------------------------------------------------------------------------
module base64_stream_encoder (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   cfg_wr_en,
    input  wire logic   cfg_wr_data,
    b64e_byte_if.sink   byte_in,
    b64e_char_if.source char_out
);
    import b64e_pkg::*;

    logic                 variant_reg;
    cmd_t                 front_cmd;
    cmd_t                 head_cmd;
    logic                 cmd_push;
    logic                 cmd_pop;
    logic                 cmd_empty;
    logic                 cmd_full;
    logic [CmdLevelW-1:0] cmd_level;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variant_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            variant_reg <= cfg_wr_data;
        end
    end

    b64e_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .url      (variant_reg),
        .byte_in  (byte_in),
        .cmd      (front_cmd),
        .cmd_push (cmd_push),
        .cmd_full (cmd_full)
    );

    b64e_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .push_cmd (front_cmd),
        .pop      (cmd_pop),
        .head     (head_cmd),
        .empty    (cmd_empty),
        .full     (cmd_full),
        .level    (cmd_level)
    );

    b64e_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .url        (variant_reg),
        .head       (head_cmd),
        .head_valid (!cmd_empty),
        .pop        (cmd_pop),
        .char_out   (char_out)
    );

    a_no_pad_url: assert property (@(posedge clk) disable iff (!rst_n)
        (char_out.valid && variant_reg) |-> (char_out.out_char != PadChar))
        else $error("pad character emitted in url-safe mode");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_level <= CmdLevelW'(CmdDepth))
        else $error("command queue overflow");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        ((!char_out.valid || char_out.ready) && cmd_level != '0) |=> char_out.valid)
        else $error("queued command not drained to output");

endmodule
`default_nettype wire

@@ verif/base64_stream_encoder_tb.sv @@
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// base64_stream_encoder_tb
// Drives message bytes into the encoder and checks every character beat
// against a cycle-free model of the base64 group logic or, for typed rows,
// against the expected text. A short directed table covers the extremes,
// padding, both alphabets and alphabet switches in the middle of a message;
// random messages follow under several idle patterns.
module base64_stream_encoder_tb;

    import b64e_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } char_beat_t;

    // typed == 0: expected characters come from the model
    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic        cfg_wr;
        logic        cfg_val;
        logic [31:0] typed;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    b64e_byte_if byte_bus ();
    b64e_char_if char_bus ();

    base64_stream_encoder DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .byte_in     (byte_bus),
        .char_out    (char_bus)
    );

    string std_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    string url_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

    logic       url_mode  = 1'b0;
    logic [1:0] grp_pos   = 2'd0;
    logic [3:0] carry     = 4'd0;

    char_beat_t pending_chars[$];
    stim_row_t  directed_rows[$];
    int         mismatch_count = 0;
    int         send_gap_pct   = 0;
    int         recv_stall_pct = 0;

    always #10 clk = ~clk;

    function automatic logic [7:0] alpha_char(input logic [5:0] idx);
        return url_mode ? url_alphabet[idx] : std_alphabet[idx];
    endfunction

    function automatic int encode_byte(input logic [7:0] b, input logic fin,
                                       output char_beat_t burst [4]);
        int n;
        n = 0;
        case (grp_pos)
            2'd1:
            begin
                burst[0] = '{alpha_char({carry[1:0], b[7:4]}), 1'b0};
                n = 1;
                carry = b[3:0];
                grp_pos = 2'd2;
                if (fin)
                begin
                    burst[1] = '{alpha_char({b[3:0], 2'b00}), 1'b0};
                    n = 2;
                    if (!url_mode)
                    begin
                        burst[2] = '{PadChar, 1'b0};
                        n = 3;
                    end
                end
            end
            2'd2:
            begin
                burst[0] = '{alpha_char({carry, b[7:6]}), 1'b0};
                burst[1] = '{alpha_char(b[5:0]), 1'b0};
                n = 2;
                carry = 4'd0;
                grp_pos = 2'd0;
            end
            default:
            begin
                burst[0] = '{alpha_char(b[7:2]), 1'b0};
                n = 1;
                carry = {2'b00, b[1:0]};
                grp_pos = 2'd1;
                if (fin)
                begin
                    burst[1] = '{alpha_char({b[1:0], 4'b0000}), 1'b0};
                    n = 2;
                    if (!url_mode)
                    begin
                        burst[2] = '{PadChar, 1'b0};
                        burst[3] = '{PadChar, 1'b0};
                        n = 4;
                    end
                end
            end
        endcase
        if (fin)
        begin
            burst[n-1].fin = 1'b1;
            carry = 4'd0;
            grp_pos = 2'd0;
        end
        return n;
    endfunction

    task automatic add_row(input logic [7:0] d, input logic l, input logic cw,
                           input logic cv, input logic [31:0] typed);
        directed_rows.push_back('{d, l, cw, cv, typed});
    endtask

    task automatic send_byte(input logic [7:0] d, input logic l, input logic [31:0] typed);
        char_beat_t burst [4];
        int         n;
        int         k;
        bit         done;
        done = 1'b0;
        while (!done)
        begin
            if ($urandom_range(1, 100) <= send_gap_pct)
            begin
                byte_bus.valid <= 1'b0;
            end
            else
            begin
                byte_bus.valid     <= 1'b1;
                byte_bus.data_byte <= d;
                byte_bus.last_byte <= l;
            end
            @(posedge clk);
            done = byte_bus.valid && byte_bus.ready;
        end
        n = encode_byte(d, l, burst);
        if (typed == '0)
        begin
            for (k = 0; k < n; k++)
            begin
                pending_chars.push_back(burst[k]);
            end
        end
        else
        begin
            for (k = 3; k >= 0; k--)
            begin
                if (typed[k*8 +: 8] != 8'h00)
                begin
                    pending_chars.push_back('{typed[k*8 +: 8], 1'b0});
                end
            end
            pending_chars[pending_chars.size()-1].fin = l;
        end
    endtask

    // only while idle: every expected beat has already come out
    task automatic write_variant(input logic v);
        byte_bus.valid <= 1'b0;
        while (pending_chars.size() != 0)
        begin
            @(posedge clk);
        end
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        url_mode = v;
    endtask

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial
    begin
        char_beat_t want;
        char_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (char_bus.valid && char_bus.ready)
            begin
                if (pending_chars.size() == 0)
                begin
                    $display("%0t: unexpected char beat: char %h last %b", $time,
                             char_bus.out_char, char_bus.last_char);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_chars.pop_front();
                    if (char_bus.out_char !== want.ch || char_bus.last_char !== want.fin)
                    begin
                        $display("%0t: mismatch: expected char %h last %b, got char %h last %b",
                                 $time, want.ch, want.fin, char_bus.out_char,
                                 char_bus.last_char);
                        mismatch_count++;
                    end
                end
            end
            char_bus.ready <= ($urandom_range(1, 100) > recv_stall_pct);
        end
    end

    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        int sent;
        int len;
        int ph;
        int i;

        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = 1'b0;
        byte_bus.valid     = 1'b0;
        byte_bus.data_byte = 8'h00;
        byte_bus.last_byte = 1'b0;

        // after reset: standard alphabet, padded
        add_row(8'h00, 1'b1, 1'b0, 1'b0, "AA==");
        add_row(8'hFF, 1'b1, 1'b0, 1'b0, "/w==");
        add_row(8'hFF, 1'b0, 1'b0, 1'b0, "/");
        add_row(8'hFF, 1'b0, 1'b0, 1'b0, "/");
        add_row(8'hFF, 1'b1, 1'b0, 1'b0, "//");
        add_row(8'h4D, 1'b0, 1'b0, 1'b0, "T");
        add_row(8'h61, 1'b1, 1'b0, 1'b0, "WE=");
        // url-safe, no padding
        add_row(8'hFB, 1'b0, 1'b1, 1'b1, "-");
        add_row(8'hFF, 1'b1, 1'b0, 1'b0, "_8");
        add_row(8'h00, 1'b1, 1'b0, 1'b0, "AA");
        add_row(8'hFF, 1'b1, 1'b0, 1'b0, "_w");
        // alphabet switched inside a message, at group positions 1 and 2
        add_row(8'hF8, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h0F, 1'b0, 1'b1, 1'b0, '0);
        add_row(8'h3E, 1'b1, 1'b1, 1'b1, '0);
        add_row(8'hFF, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'hFB, 1'b1, 1'b1, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b1, 1'b0, 1'b0, '0);
        add_row(8'h80, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h01, 1'b1, 1'b0, 1'b0, '0);
        add_row(8'hA5, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h5A, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'hC3, 1'b1, 1'b0, 1'b0, '0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        url_mode = 1'b0;
        grp_pos  = 2'd0;
        carry    = 4'd0;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].cfg_wr)
            begin
                write_variant(directed_rows[r].cfg_val);
            end
            send_byte(directed_rows[r].data, directed_rows[r].last, directed_rows[r].typed);
        end

        for (ph = 0; ph < 8; ph++)
        begin
            write_variant(ph[0]);
            case (ph / 2)
                0:       begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_gap_pct = 54; recv_stall_pct = 0;  end
                2:       begin send_gap_pct = 0;  recv_stall_pct = 54; end
                default: begin send_gap_pct = 36; recv_stall_pct = 36; end
            endcase
            sent = 0;
            while (sent < 37)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24)
                                                  : $urandom_range(1, 6);
                for (i = 0; i < len; i++)
                begin
                    send_byte(rand_byte(), i == len - 1, '0);
                end
                sent += len;
            end
        end

        byte_bus.valid <= 1'b0;
        while (pending_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
